@@ sv/srp_pkg.sv @@
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants shared by the shelf rectangle packer modules.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int DimW   = 15;
  localparam int PosW   = 14;
  localparam int ShelfW = 6;
  localparam int ModeW  = 3;
  localparam int CfgW   = 2;

  localparam logic [DimW-1:0] AtlasReset = 15'd1024;

  localparam logic [CfgW-1:0] CfgAtlasWidth  = 2'd0;
  localparam logic [CfgW-1:0] CfgAtlasHeight = 2'd1;
  localparam logic [CfgW-1:0] CfgMode        = 2'd2;
  localparam logic [CfgW-1:0] CfgRotate      = 2'd3;

  localparam logic [ModeW-1:0] ModeNext       = 3'd0;
  localparam logic [ModeW-1:0] ModeFirst      = 3'd1;
  localparam logic [ModeW-1:0] ModeBestArea   = 3'd2;
  localparam logic [ModeW-1:0] ModeWorstArea  = 3'd3;
  localparam logic [ModeW-1:0] ModeBestHeight = 3'd4;
  localparam logic [ModeW-1:0] ModeBestWidth  = 3'd5;
  localparam logic [ModeW-1:0] ModeWorstWidth = 3'd6;

  localparam logic ActPlace = 1'b0;
  localparam logic ActClear = 1'b1;

  typedef struct packed {
    logic            action;
    logic [DimW-1:0] rect_width;
    logic [DimW-1:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic              placed;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic [DimW-1:0]   placed_width;
    logic [DimW-1:0]   placed_height;
    logic              rotated;
    logic [ShelfW-1:0] shelf_number;
  } out_item_t;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StClear,
    StScan,
    StDrain1,
    StDrain2,
    StDone
  } state_t;

  typedef struct packed {
    logic zero_shelf;
    logic emit_zero;
    logic load;
    logic rd_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctrl_status_t;

endpackage

@@ sv/srp_ram.sv @@
// ----------------------------------------------------------------------------
// srp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module srp_ram #(
  parameter int Width = 45,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/srp_ctrl.sv @@
// ----------------------------------------------------------------------------
// srp_ctrl
// Sequencer: initializes shelf 0, runs the shelf scan and finishes each request.
// ----------------------------------------------------------------------------
module srp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 action,
  input  srp_pkg::ctrl_status_t status,
  output srp_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  import srp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StInit;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      StInit: begin
        cmd.zero_shelf = 1'b1;
        state_next = StIdle;
      end
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          if (action == ActClear) begin
            state_next = StClear;
          end else begin
            cmd.load = 1'b1;
            state_next = StScan;
          end
        end
      end
      StClear: begin
        cmd.zero_shelf = 1'b1;
        cmd.emit_zero = 1'b1;
        state_next = StIdle;
      end
      StScan: begin
        cmd.rd_en = 1'b1;
        if (status.scan_last) begin
          state_next = StDrain1;
        end
      end
      StDrain1: state_next = StDrain2;
      StDrain2: state_next = StDone;
      StDone: begin
        cmd.finish = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StInit;
    endcase
  end

endmodule

@@ sv/srp_datapath.sv @@
// ----------------------------------------------------------------------------
// srp_datapath
// Configuration, shelf store, scoring pipeline, best-shelf tracking and result.
// ----------------------------------------------------------------------------
module srp_datapath #(
  parameter int MaxShelves = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  srp_pkg::ctrl_cmd_t     cmd,
  output srp_pkg::ctrl_status_t  status,
  input  srp_pkg::in_item_t      item,
  input  logic                   cfg_en,
  input  logic [srp_pkg::CfgW-1:0] cfg_addr,
  input  logic [srp_pkg::DimW-1:0] cfg_data,
  output logic                   done,
  output srp_pkg::out_item_t     result
);

  import srp_pkg::*;

  localparam int AW = (MaxShelves > 1) ? $clog2(MaxShelves) : 1;
  localparam int CW = $clog2(MaxShelves + 1);
  localparam int EW = 3 * DimW;
  localparam logic [CW-1:0] CountMax = CW'(MaxShelves);

  logic [DimW-1:0]  atlas_width;
  logic [DimW-1:0]  atlas_height;
  logic [ModeW-1:0] mode;
  logic             allow_rotate;

  logic [CW-1:0]   count;
  logic [AW-1:0]   last;
  logic [AW-1:0]   addr;
  logic [DimW-1:0] w;
  logic [DimW-1:0] h;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;

  logic            p0_valid;
  logic [AW-1:0]   p0_idx;

  logic                  s1_valid;
  logic [AW-1:0]         s1_idx;
  logic                  s1_fit;
  logic                  s1_rot;
  logic                  s1_last;
  logic signed [33:0]    s1_score;
  logic [DimW-1:0]       s1_fill;
  logic [DimW-1:0]       s1_top;
  logic [DimW-1:0]       s1_tall;

  logic                  best_found;
  logic [AW-1:0]         best_idx;
  logic                  best_rot;
  logic signed [33:0]    best_score;
  logic [DimW-1:0]       best_fill;
  logic [DimW-1:0]       best_top;
  logic [DimW-1:0]       best_tall;
  logic [DimW-1:0]       last_top;
  logic [DimW-1:0]       last_tall;

  logic [DimW-1:0]       rd_fill, rd_top, rd_tall;
  logic                  p0_last, want_rot, rot, fit;
  logic [DimW-1:0]       tw, th;
  logic signed [16:0]    free_w;
  logic signed [33:0]    area;
  logic signed [16:0]    hdiff;
  logic signed [17:0]    wleft;
  logic signed [33:0]    score;
  logic                  better;

  logic [DimW-1:0]       fw, fh;
  logic [DimW:0]         base;
  logic                  can_open;
  logic [DimW-1:0]       new_tall;
  logic [DimW:0]         new_fill;
  out_item_t             result_next;

  assign last = AW'(count - CW'(1));
  assign status.scan_last = (addr == last);

  srp_ram #(.Width(EW), .Depth(MaxShelves)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign rd_fill = ram_rdata[3*DimW-1:2*DimW];
  assign rd_top  = ram_rdata[2*DimW-1:DimW];
  assign rd_tall = ram_rdata[DimW-1:0];

  always_comb begin
    p0_last = (p0_idx == last);
    free_w = $signed({2'b00, atlas_width}) - $signed({2'b00, rd_fill});
    want_rot = 1'b0;
    if (w > h && ({1'b0, w} + {1'b0, rd_fill}) > {1'b0, atlas_width}) want_rot = 1'b1;
    if (w > h && w < rd_tall) want_rot = 1'b1;
    if (w < h && h > rd_tall && ({1'b0, h} + {1'b0, rd_fill}) <= {1'b0, atlas_width})
      want_rot = 1'b1;
    rot = allow_rotate && (mode >= ModeBestArea) && (mode <= ModeWorstWidth) && want_rot;
    tw = rot ? h : w;
    th = rot ? w : h;
    fit = (({1'b0, rd_fill} + {1'b0, tw}) <= {1'b0, atlas_width}) &&
          (p0_last ? (({1'b0, rd_top} + {1'b0, th}) <= {1'b0, atlas_height})
                   : (th <= rd_tall));
    area = free_w * $signed({1'b0, rd_tall});
    hdiff = $signed({2'b00, rd_tall}) - $signed({2'b00, th});
    wleft = $signed({3'b000, atlas_width}) - $signed({3'b000, rd_fill})
          - $signed({3'b000, tw});
    case (mode)
      ModeBestArea, ModeWorstArea: score = area;
      ModeBestHeight: score = hdiff[16] ? 34'sd0 : 34'(hdiff);
      default: score = 34'(wleft);
    endcase
  end

  always_comb begin
    better = 1'b0;
    if (s1_fit) begin
      case (mode)
        ModeNext:       better = s1_last;
        ModeFirst:      better = !best_found;
        ModeBestArea:   better = !best_found || s1_score < best_score;
        ModeWorstArea:  better = !best_found || s1_score > best_score;
        ModeBestHeight: better = !best_found || s1_score < best_score;
        ModeBestWidth:  better = s1_score >= 0 && (!best_found || s1_score < best_score);
        ModeWorstWidth: better = s1_score > 0 && (!best_found || s1_score > best_score);
        default:        better = 1'b0;
      endcase
    end
  end

  always_comb begin
    fw = best_rot ? h : w;
    fh = best_rot ? w : h;
    base = {1'b0, last_top} + {1'b0, last_tall};
    can_open = (mode <= ModeWorstWidth) && (count < CountMax) &&
               (({1'b0, base} + {2'b00, h}) <= {2'b00, atlas_height}) && (w <= atlas_width);
    new_fill = {1'b0, best_fill} + {1'b0, fw};
    new_tall = (fh > best_tall) ? fh : best_tall;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    result_next = '0;
    if (cmd.zero_shelf) begin
      ram_we = 1'b1;
    end else if (cmd.finish) begin
      if (best_found) begin
        ram_we = 1'b1;
        ram_waddr = best_idx;
        ram_wdata = {new_fill[DimW-1:0], best_top, new_tall};
        result_next.placed        = 1'b1;
        result_next.pos_x         = best_fill[PosW-1:0];
        result_next.pos_y         = best_top[PosW-1:0];
        result_next.placed_width  = fw;
        result_next.placed_height = fh;
        result_next.rotated       = best_rot;
        result_next.shelf_number  = ShelfW'(best_idx);
      end else if (can_open) begin
        ram_we = 1'b1;
        ram_waddr = AW'(count);
        ram_wdata = {w, base[DimW-1:0], h};
        result_next.placed        = 1'b1;
        result_next.pos_y         = base[PosW-1:0];
        result_next.placed_width  = w;
        result_next.placed_height = h;
        result_next.shelf_number  = ShelfW'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= AtlasReset;
      atlas_height <= AtlasReset;
      mode         <= ModeBestArea;
      allow_rotate <= 1'b0;
      count        <= CW'(1);
      p0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      best_found   <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_en) begin
        case (cfg_addr)
          CfgAtlasWidth:  atlas_width  <= cfg_data;
          CfgAtlasHeight: atlas_height <= cfg_data;
          CfgMode:        mode         <= cfg_data[ModeW-1:0];
          CfgRotate:      allow_rotate <= cfg_data[0];
          default: ;
        endcase
      end
      p0_valid <= cmd.rd_en;
      s1_valid <= p0_valid;
      done <= cmd.finish || cmd.emit_zero;
      if (cmd.zero_shelf) begin
        count <= CW'(1);
      end else if (cmd.finish && !best_found && can_open) begin
        count <= count + CW'(1);
      end
      if (cmd.load) begin
        best_found <= 1'b0;
      end else if (s1_valid && better) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w <= item.rect_width;
      h <= item.rect_height;
      addr <= '0;
    end else if (cmd.rd_en && !status.scan_last) begin
      addr <= addr + AW'(1);
    end
    p0_idx   <= addr;
    s1_idx   <= p0_idx;
    s1_fit   <= fit;
    s1_rot   <= rot;
    s1_last  <= p0_last;
    s1_score <= score;
    s1_fill  <= rd_fill;
    s1_top   <= rd_top;
    s1_tall  <= rd_tall;
    if (s1_valid && better) begin
      best_idx   <= s1_idx;
      best_rot   <= s1_rot;
      best_score <= s1_score;
      best_fill  <= s1_fill;
      best_top   <= s1_top;
      best_tall  <= s1_tall;
    end
    if (s1_valid && s1_last) begin
      last_top  <= s1_top;
      last_tall <= s1_tall;
    end
    if (cmd.emit_zero || cmd.finish) begin
      result <= result_next;
    end
  end

endmodule

@@ sv/shelf_rectangle_packer.sv @@
// ----------------------------------------------------------------------------
// shelf_rectangle_packer
// Allocates rectangles onto horizontal shelves of a texture atlas.
//
//   Channel   Signals                          Handshake
//   request   start, item                      taken when start and not busy
//   result    done, result                     one-cycle strobe, no back-pressure
//   config    cfg_en, cfg_addr, cfg_data       written when cfg_en is high
//
// A placement request scans the open shelves through the shelf RAM read port,
// one shelf per cycle. A clear request resets the store to shelf 0. After
// reset the block initializes shelf 0 before it accepts a request.
// ----------------------------------------------------------------------------
module shelf_rectangle_packer #(
  parameter int MaxShelves = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  srp_pkg::in_item_t         item,
  input  logic                      cfg_en,
  input  logic [srp_pkg::CfgW-1:0]  cfg_addr,
  input  logic [srp_pkg::DimW-1:0]  cfg_data,
  output logic                      done,
  output srp_pkg::out_item_t        result
);

  import srp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  srp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  srp_datapath #(.MaxShelves(MaxShelves)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .item     (item),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the shelf rectangle packer. A directed table
// covers clears and size extremes; directed runs test every placement mode
// and shelf exhaustion, then random placement requests run under several
// atlas settings. Each result is compared with the testbench's shelf model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import srp_pkg::*;

  localparam int Shelves = 64;
  localparam int WatchLimit = 20000;

  typedef struct {
    logic      use_exp;
    in_item_t  req;
    out_item_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic cfg_en = 1'b0;
  logic [CfgW-1:0] cfg_addr = '0;
  logic [DimW-1:0] cfg_data = '0;
  logic done;
  out_item_t result;

  shelf_rectangle_packer #(.MaxShelves(Shelves)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_en(cfg_en), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  logic [DimW-1:0] atlas_w, atlas_h;
  logic [ModeW-1:0] mode;
  logic rot_en;
  logic [DimW-1:0] fill[Shelves];
  logic [DimW-1:0] top[Shelves];
  logic [DimW-1:0] tall[Shelves];
  int open_count;

  out_item_t placements[$];
  out_item_t directed_exp[$];
  logic directed_use[$];
  int errors = 0;
  int idle_cycles = 0;
  logic no_idle = 1'b0;

  task automatic report(input string what, input out_item_t got, input out_item_t exp);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  function automatic void empty_atlas();
    for (int i = 0; i < Shelves; i++) begin
      fill[i] = '0;
      top[i] = '0;
      tall[i] = '0;
    end
    open_count = 1;
  endfunction

  function automatic logic fits_on(int i, longint w, longint h, logic last_one);
    longint room;
    room = last_one ? longint'(atlas_h) - longint'(top[i]) : longint'(tall[i]);
    return (longint'(fill[i]) + w <= longint'(atlas_w)) && (h <= room);
  endfunction

  function automatic logic turn_wanted(int i, longint w, longint h);
    longint free_w;
    longint t;
    free_w = longint'(atlas_w) - longint'(fill[i]);
    t = longint'(tall[i]);
    return (w > h && w > free_w) || (w > h && w < t) || (w < h && h > t && h <= free_w);
  endfunction

  function automatic out_item_t place_rect(in_item_t req);
    out_item_t r;
    longint w, h, tw, th, score, best;
    int pick, last_i;
    logic found, best_rot, rot, better;
    r = '0;
    best = 0;
    pick = 0;
    found = 1'b0;
    best_rot = 1'b0;
    if (req.action == ActClear) begin
      empty_atlas();
      return r;
    end
    w = req.rect_width;
    h = req.rect_height;
    if (mode > ModeWorstWidth) return r;
    last_i = open_count - 1;
    if (mode == ModeNext) begin
      if (fits_on(last_i, w, h, 1'b1)) begin
        found = 1'b1;
        pick = last_i;
      end
    end else if (mode == ModeFirst) begin
      for (int i = 0; i < open_count && !found; i++) begin
        if (fits_on(i, w, h, i == last_i)) begin
          found = 1'b1;
          pick = i;
        end
      end
    end else begin
      for (int i = 0; i < open_count; i++) begin
        rot = rot_en && turn_wanted(i, w, h);
        tw = rot ? h : w;
        th = rot ? w : h;
        if (fits_on(i, tw, th, i == last_i)) begin
          case (mode)
            ModeBestArea: begin
              score = (longint'(atlas_w) - longint'(fill[i])) * longint'(tall[i]);
              better = !found || score < best;
            end
            ModeWorstArea: begin
              score = (longint'(atlas_w) - longint'(fill[i])) * longint'(tall[i]);
              better = !found || score > best;
            end
            ModeBestHeight: begin
              score = longint'(tall[i]) - th;
              if (score < 0) score = 0;
              better = !found || score < best;
            end
            ModeBestWidth: begin
              score = longint'(atlas_w) - longint'(fill[i]) - tw;
              better = score >= 0 && (!found || score < best);
            end
            default: begin
              score = longint'(atlas_w) - longint'(fill[i]) - tw;
              better = score > 0 && (!found || score > best);
            end
          endcase
          if (better) begin
            found = 1'b1;
            pick = i;
            best = score;
            best_rot = rot;
          end
        end
      end
    end
    if (found) begin
      tw = best_rot ? h : w;
      th = best_rot ? w : h;
    end else begin
      score = longint'(top[last_i]) + longint'(tall[last_i]);
      if (open_count >= Shelves || score + h > longint'(atlas_h) || w > longint'(atlas_w))
        return r;
      pick = open_count;
      top[pick] = score[DimW-1:0];
      fill[pick] = '0;
      tall[pick] = h[DimW-1:0];
      open_count++;
      best_rot = 1'b0;
      tw = w;
      th = h;
    end
    r.placed = 1'b1;
    r.pos_x = fill[pick][PosW-1:0];
    r.pos_y = top[pick][PosW-1:0];
    r.placed_width = tw[DimW-1:0];
    r.placed_height = th[DimW-1:0];
    r.rotated = best_rot;
    r.shelf_number = pick[ShelfW-1:0];
    fill[pick] = fill[pick] + tw[DimW-1:0];
    if (th[DimW-1:0] > tall[pick]) tall[pick] = th[DimW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      idle_cycles <= 0;
      if (placements.size() == 0) begin
        report("unexpected", result, '0);
      end else begin
        if (result !== placements[0]) report("placement", result, placements[0]);
        if (directed_use[0] && result !== directed_exp[0])
          report("table", result, directed_exp[0]);
        void'(placements.pop_front());
        void'(directed_exp.pop_front());
        void'(directed_use.pop_front());
      end
    end else if (!rst && !(start && !busy)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_cfg(input logic [CfgW-1:0] idx, input logic [DimW-1:0] val);
    cfg_en <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      CfgAtlasWidth: atlas_w = val;
      CfgAtlasHeight: atlas_h = val;
      CfgMode: mode = val[ModeW-1:0];
      default: rot_en = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (placements.size() != 0) @(posedge clk);
    repeat (Shelves + 10) @(posedge clk);
  endtask

  task automatic send(input in_item_t req, input logic use_exp, input out_item_t exp);
    while (!no_idle && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    placements.insert(placements.size(), place_rect(req));
    directed_exp.insert(directed_exp.size(), exp);
    directed_use.insert(directed_use.size(), use_exp);
  endtask

  function automatic in_item_t rect(logic act, int w, int h);
    in_item_t r;
    r.action = act;
    r.rect_width = w[DimW-1:0];
    r.rect_height = h[DimW-1:0];
    return r;
  endfunction

  function automatic out_item_t hit(int x, int y, int w, int h, logic rt, int s);
    out_item_t r;
    r.placed = 1'b1;
    r.pos_x = x[PosW-1:0];
    r.pos_y = y[PosW-1:0];
    r.placed_width = w[DimW-1:0];
    r.placed_height = h[DimW-1:0];
    r.rotated = rt;
    r.shelf_number = s[ShelfW-1:0];
    return r;
  endfunction

  task automatic random_phase(input int count, input int max_dim);
    in_item_t req;
    for (int k = 0; k < count; k++) begin
      req.action = ($urandom_range(99) < 3) ? ActClear : ActPlace;
      if ($urandom_range(99) < 5) begin
        req.rect_width = DimW'($urandom);
        req.rect_height = DimW'($urandom);
      end else begin
        req.rect_width = DimW'($urandom_range(max_dim));
        req.rect_height = DimW'($urandom_range(max_dim));
      end
      send(req, 1'b0, '0);
    end
  endtask

  row_t table_rows[$];

  task automatic add_row(input logic use_exp, input in_item_t req, input out_item_t exp);
    row_t r;
    r.use_exp = use_exp;
    r.req = req;
    r.exp = exp;
    table_rows.insert(table_rows.size(), r);
  endtask

  initial begin
    empty_atlas();
    atlas_w = AtlasReset;
    atlas_h = AtlasReset;
    mode = ModeBestArea;
    rot_en = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(1'b1, rect(ActPlace, 10, 20), hit(0, 0, 10, 20, 1'b0, 0));
    add_row(1'b1, rect(ActPlace, 1024, 5), hit(0, 20, 1024, 5, 1'b0, 1));
    add_row(1'b1, rect(ActPlace, 1025, 1), '0);
    add_row(1'b1, rect(ActPlace, 1, 1024), '0);
    add_row(1'b1, rect(ActClear, 7, 7), '0);
    add_row(1'b1, rect(ActPlace, 0, 0), hit(0, 0, 0, 0, 1'b0, 0));
    add_row(1'b1, rect(ActPlace, 32767, 32767), '0);
    add_row(1'b1, rect(ActPlace, 1024, 1024), hit(0, 0, 1024, 1024, 1'b0, 0));
    add_row(1'b1, rect(ActClear, 32767, 32767), '0);
    foreach (table_rows[i]) send(table_rows[i].req, table_rows[i].use_exp, table_rows[i].exp);
    drain();

    for (int m = 0; m <= 7; m++) begin
      write_cfg(CfgMode, m[DimW-1:0]);
      write_cfg(CfgRotate, DimW'(m[0]));
      send(rect(ActClear, 0, 0), 1'b1, '0);
      send(rect(ActPlace, 30, 10), 1'b0, '0);
      send(rect(ActPlace, 10, 30), 1'b0, '0);
      send(rect(ActPlace, 500, 8), 1'b0, '0);
      drain();
    end

    write_cfg(CfgAtlasWidth, 15'd4);
    write_cfg(CfgAtlasHeight, 15'd16384);
    write_cfg(CfgMode, {12'd0, ModeFirst});
    send(rect(ActClear, 0, 0), 1'b1, '0);
    for (int k = 0; k < 66; k++) send(rect(ActPlace, 4, 1), 1'b0, '0);
    drain();

    write_cfg(CfgAtlasWidth, 15'd32767);
    write_cfg(CfgAtlasHeight, 15'd32767);
    for (int p = 0; p < 7; p++) begin
      write_cfg(CfgMode, DimW'($urandom_range(7)));
      write_cfg(CfgRotate, DimW'($urandom_range(1)));
      case (p)
        0: begin
          write_cfg(CfgAtlasWidth, 15'd1);
          write_cfg(CfgAtlasHeight, 15'd1);
        end
        1: begin
          write_cfg(CfgAtlasWidth, 15'd16384);
          write_cfg(CfgAtlasHeight, 15'd16384);
        end
        2: begin
          write_cfg(CfgAtlasWidth, 15'd32767);
          write_cfg(CfgAtlasHeight, 15'd32767);
        end
        default: begin
          write_cfg(CfgAtlasWidth, DimW'($urandom_range(64, 1024)));
          write_cfg(CfgAtlasHeight, DimW'($urandom_range(64, 1024)));
        end
      endcase
      no_idle = (p == 4);
      send(rect(ActClear, 0, 0), 1'b0, '0);
      random_phase(110, (p < 3) ? 4000 : 200);
      drain();
    end
    no_idle = 1'b0;
    write_cfg(CfgMode, {12'd0, ModeWorstWidth});
    write_cfg(CfgRotate, 15'd1);
    random_phase(100, 100);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/srp_pkg.sv
sv/srp_ram.sv
sv/srp_ctrl.sv
sv/srp_datapath.sv
sv/shelf_rectangle_packer.sv
test/tb.sv
